/* hw/rtl/mlfs_pkg.sv */
// ----------------------------------------------------------------------------
// mlfs_pkg
// Shared types, constants and frame builder for the Manchester LED frame
// serializer.
// ----------------------------------------------------------------------------
package mlfs_pkg;

    localparam int COLOR_BITS = 13;
    localparam int COLOR_IN_W = 13;
    localparam int HALF_W     = 16;
    localparam int CELL_LEN_W = HALF_W + 1;

    localparam int SYNC_BITS = 30;
    localparam int PRE_BITS  = 19;
    localparam int RGB_BITS  = 3 * COLOR_BITS;

    // Longest frame sets the shift register width
    localparam int FRAME_W = (RGB_BITS > SYNC_BITS) ? RGB_BITS : SYNC_BITS;
    localparam int CNT_W   = $clog2(FRAME_W + 1);
    localparam int CEXT_W  = (COLOR_BITS > COLOR_IN_W) ? COLOR_BITS : COLOR_IN_W;

    localparam logic [31:0] SYNC_PATTERN  = 32'hFFFE_2000;
    localparam logic [31:0] RESET_PATTERN = 32'hFFFE_8000;
    localparam logic [31:0] HEAD_PATTERN  = 32'hFFFE_4000;

    localparam logic [HALF_W-1:0] HALF_BIT_RESET = HALF_W'(26);

    typedef enum logic [1:0] {
        CMD_SYNC  = 2'd0,
        CMD_RESET = 2'd1,
        CMD_HEAD  = 2'd2,
        CMD_RGB   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [COLOR_IN_W-1:0] red;
        logic [COLOR_IN_W-1:0] green;
        logic [COLOR_IN_W-1:0] blue;
    } t_in;

    typedef struct packed {
        logic first_half;
        logic second_half;
        logic end_low;
        logic last;
    } t_out;

    // One frame ready for the shifter: bits left aligned, MSB goes first
    typedef struct packed {
        logic [FRAME_W-1:0] bits;
        logic [CNT_W-1:0]   count;
        logic               preamble;
    } t_frame;

    // Low COLOR_BITS of a colour; positions above the input field read as zero
    function automatic logic [COLOR_BITS-1:0] f_colour(input logic [COLOR_IN_W-1:0] v);
        logic [CEXT_W-1:0] ext;
        ext = CEXT_W'(v);
        return ext[COLOR_BITS-1:0];
    endfunction

    // Top FRAME_W bits of a 32-bit pattern, zero filled below
    function automatic logic [FRAME_W-1:0] f_align(input logic [31:0] pat);
        logic [FRAME_W+31:0] tmp;
        tmp = {pat, FRAME_W'(0)};
        return tmp[FRAME_W+31 -: FRAME_W];
    endfunction

    function automatic t_frame f_frame(input t_in item);
        t_frame                       fr;
        logic [RGB_BITS+FRAME_W-1:0]  tmp;
        tmp = {f_colour(item.red), f_colour(item.green), f_colour(item.blue),
               FRAME_W'(0)};
        case (item.cmd)
            CMD_SYNC: begin
                fr.bits     = f_align(SYNC_PATTERN);
                fr.count    = CNT_W'(SYNC_BITS);
                fr.preamble = 1'b1;
            end
            CMD_RESET: begin
                fr.bits     = f_align(RESET_PATTERN);
                fr.count    = CNT_W'(PRE_BITS);
                fr.preamble = 1'b1;
            end
            CMD_HEAD: begin
                fr.bits     = f_align(HEAD_PATTERN);
                fr.count    = CNT_W'(PRE_BITS);
                fr.preamble = 1'b1;
            end
            default: begin
                fr.bits     = tmp[RGB_BITS+FRAME_W-1 -: FRAME_W];
                fr.count    = CNT_W'(RGB_BITS);
                fr.preamble = 1'b0;
            end
        endcase
        return fr;
    endfunction

endpackage

/* hw/rtl/manchester_led_frame_serializer_unit.sv */
// ----------------------------------------------------------------------------
// manchester_led_frame_serializer_unit
// Turns sync, reset, head and RGB pixel commands into Manchester bit cells,
// one output beat per cell, MSB first.
// ----------------------------------------------------------------------------
// Path: on an idle line a frame's first cell passes the input register, the
//   shifter and the output register; later while a cell period still runs.
// Rate: one cell beat per cell period from the cell timer while the output
//   is not stalled; frames of 19, 30 or 3*COLOR_BITS cells run back to
//   back, the next command waiting in the input register while one shifts.
// Reset: synchronous active low; clears valid flags and cell timer, half_bit 26.
module manchester_led_frame_serializer_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // command beats
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  mlfs_pkg::t_in               i_in_data,
    // cell beats
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output mlfs_pkg::t_out              o_out_data,
    // half_bit_cycles register
    input  logic                        i_cfg_wr_en,
    input  logic [mlfs_pkg::HALF_W-1:0] i_cfg_wr_data
);
    import mlfs_pkg::*;

    // Input register: holds the next command while the shifter is busy
    logic              r_in_valid;
    t_in               r_in;
    logic              n_in_valid;
    logic [HALF_W-1:0] r_half;

    logic                  load_ready;
    t_frame                frame;
    logic [HALF_W-1:0]     half_eff;
    logic [CELL_LEN_W-1:0] cell_len;

    assign o_in_ready = !r_in_valid || load_ready;

    // Frame bits from the held command: short constant select, no state
    assign frame = f_frame(r_in);

    // A zero half-bit length is treated as one; a cell is two halves
    assign half_eff = (r_half == '0) ? HALF_W'(1) : r_half;
    assign cell_len = {half_eff, 1'b0};

    always_comb begin
        n_in_valid = r_in_valid;
        if (r_in_valid && load_ready) begin
            n_in_valid = 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            n_in_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_half     <= HALF_BIT_RESET;
        end else begin
            r_in_valid <= n_in_valid;
            if (i_cfg_wr_en) begin
                r_half <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Shift register, cell timer and output register
    mlfs_shifter u_shifter (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_in_valid),
        .i_load       (frame),
        .o_load_ready (load_ready),
        .i_cell_len   (cell_len),
        .o_cell_valid (o_out_valid),
        .o_cell       (o_out_data),
        .i_cell_ready (i_out_ready)
    );

endmodule

/* hw/rtl/mlfs_shifter.sv */
// ----------------------------------------------------------------------------
// mlfs_shifter
// Shifts one frame out as bit cells, MSB first, one cell per cell period,
// into an output register, holding while that register is stalled.
// ----------------------------------------------------------------------------
module mlfs_shifter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load_valid,
    input  mlfs_pkg::t_frame                i_load,
    output logic                            o_load_ready,
    input  logic [mlfs_pkg::CELL_LEN_W-1:0] i_cell_len,
    output logic                            o_cell_valid,
    output mlfs_pkg::t_out                  o_cell,
    input  logic                            i_cell_ready
);
    import mlfs_pkg::*;

    logic                  r_busy, n_busy;
    logic [FRAME_W-1:0]    r_bits, n_bits;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_pre, n_pre;
    logic [CELL_LEN_W-1:0] r_tmr, n_tmr;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    logic out_free, emit, last_cell, load;

    assign out_free     = !r_out_valid || i_cell_ready;
    assign emit         = r_busy && (r_tmr == '0) && out_free;
    assign last_cell    = (r_cnt == CNT_W'(1));
    assign o_load_ready = !r_busy || (emit && last_cell);
    assign load         = i_load_valid && o_load_ready;

    always_comb begin
        n_busy      = r_busy;
        n_bits      = r_bits;
        n_cnt       = r_cnt;
        n_pre       = r_pre;
        n_tmr       = r_tmr;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_cell_ready) begin
            n_out_valid = 1'b0;
        end
        if (r_tmr != '0) begin
            n_tmr = r_tmr - CELL_LEN_W'(1);
        end
        if (emit) begin
            n_out_valid       = 1'b1;
            n_out.first_half  = r_bits[FRAME_W-1];
            n_out.second_half = !r_bits[FRAME_W-1];
            n_out.last        = last_cell;
            n_out.end_low     = r_pre && last_cell;
            n_bits            = {r_bits[FRAME_W-2:0], 1'b0};
            n_cnt             = r_cnt - CNT_W'(1);
            n_tmr             = i_cell_len - CELL_LEN_W'(1);
            if (last_cell) begin
                n_busy = 1'b0;
            end
        end
        if (load) begin
            n_busy = 1'b1;
            n_bits = i_load.bits;
            n_cnt  = i_load.count;
            n_pre  = i_load.preamble;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_tmr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_tmr       <= n_tmr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_cnt  <= n_cnt;
        r_pre  <= n_pre;
        r_out  <= n_out;
    end

    assign o_cell_valid = r_out_valid;
    assign o_cell       = r_out;

endmodule

/* hw/rtl/mlfs_checker.sv */
// ----------------------------------------------------------------------------
// mlfs_checker
// Port-level checks for the Manchester LED frame serializer, bound to the top.
// ----------------------------------------------------------------------------
module mlfs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input mlfs_pkg::t_out              o_out_data
);
    import mlfs_pkg::*;

    // Stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("cell beat changed while stalled");

    // Manchester halves are always opposite
    a_halves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.second_half == !o_out_data.first_half))
        else $error("cell halves not complementary");

    // Line forced low only at a frame end
    a_end_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.end_low |-> o_out_data.last)
        else $error("end_low outside last cell");

    // Empty after reset: ready to take a command, nothing to send
    a_post_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> o_in_ready && !o_out_valid)
        else $error("not empty after reset");

endmodule

bind manchester_led_frame_serializer_unit mlfs_checker u_mlfs_checker (.*);

/* sim/manchester_led_frame_serializer_unit_tb.sv */
// ----------------------------------------------------------------------------
// manchester_led_frame_serializer_unit_tb
// Self-checking bench: command beats in, Manchester cell beats out. A table
// of directed commands runs first, then random commands over several
// half-bit lengths. Every cell beat is compared field by field with its
// directed row or an in-bench frame predictor. Both sides idle at random,
// and the cell side holds off for long stretches so the block backs up.
// ----------------------------------------------------------------------------
module manchester_led_frame_serializer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlfs_pkg::*;

    // Frame constants as the line protocol defines them
    localparam logic [31:0] SYNC_WORD  = 32'hFFFE_2000;
    localparam logic [31:0] RESET_WORD = 32'hFFFE_8000;
    localparam logic [31:0] HEAD_WORD  = 32'hFFFE_4000;
    localparam int SYNC_LEN = 30;
    localparam int PRE_LEN  = 19;
    localparam int LED_BITS = 13;

    // Worst correct run is ~410 commands of up to 39 cells, plus stalls,
    // at the reset half-bit length; everything here runs far shorter.
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int N_PHASES    = 6;
    localparam int N_DIRECTED  = 20;

    // One directed row; cells/ncells/ends_low only used where typed is set
    typedef struct packed {
        t_cmd        cmd;
        logic [12:0] red;
        logic [12:0] green;
        logic [12:0] blue;
        bit          typed;
        logic [38:0] cells;
        logic [5:0]  ncells;
        bit          ends_low;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    t_in         i_in_data     = '0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    t_out        o_out_data;
    logic        i_cfg_wr_en   = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;

    t_out        cells_due[$];
    int          mismatch_count = 0;
    int          cell_beats     = 0;
    int          cycle_count    = 0;
    int          hold_left      = 0;
    bit          hold_req       = 1'b0;
    bit          steady         = 1'b0;
    int unsigned half_now       = 26;
    int unsigned last_item_half = 26;

    int unsigned phase_half  [N_PHASES] = '{0, 1, 2, 26, 3, 1};
    int          phase_items [N_PHASES] = '{70, 70, 70, 30, 80, 70};

    t_dir_row directed_rows [N_DIRECTED] = '{
        // preambles, colours clear
        '{CMD_SYNC,  13'h0000, 13'h0000, 13'h0000, 1'b1, 39'h00_3FFF_8800, 6'd30, 1'b1},
        '{CMD_RESET, 13'h0000, 13'h0000, 13'h0000, 1'b1, 39'h00_0007_FFF4, 6'd19, 1'b1},
        '{CMD_HEAD,  13'h0000, 13'h0000, 13'h0000, 1'b1, 39'h00_0007_FFF2, 6'd19, 1'b1},
        // pixel extremes
        '{CMD_RGB,   13'h0000, 13'h0000, 13'h0000, 1'b1, 39'h00_0000_0000, 6'd39, 1'b0},
        '{CMD_RGB,   13'h1FFF, 13'h1FFF, 13'h1FFF, 1'b1, 39'h7F_FFFF_FFFF, 6'd39, 1'b0},
        '{CMD_RGB,   13'h1FFF, 13'h0000, 13'h0000, 1'b1, 39'h7F_FC00_0000, 6'd39, 1'b0},
        '{CMD_RGB,   13'h0000, 13'h1FFF, 13'h0000, 1'b1, 39'h00_03FF_E000, 6'd39, 1'b0},
        '{CMD_RGB,   13'h0000, 13'h0000, 13'h1FFF, 1'b1, 39'h00_0000_1FFF, 6'd39, 1'b0},
        // colours must be ignored on preambles
        '{CMD_SYNC,  13'h1FFF, 13'h1FFF, 13'h1FFF, 1'b1, 39'h00_3FFF_8800, 6'd30, 1'b1},
        '{CMD_RESET, 13'h1555, 13'h0AAA, 13'h1FFF, 1'b1, 39'h00_0007_FFF4, 6'd19, 1'b1},
        '{CMD_HEAD,  13'h1FFF, 13'h1FFF, 13'h1FFF, 1'b1, 39'h00_0007_FFF2, 6'd19, 1'b1},
        // the rest go through the predictor
        '{CMD_RGB,   13'h0001, 13'h0001, 13'h0001, 1'b0, 39'h0, 6'd0, 1'b0},
        '{CMD_RGB,   13'h1000, 13'h1000, 13'h1000, 1'b0, 39'h0, 6'd0, 1'b0},
        '{CMD_RGB,   13'h1555, 13'h0AAA, 13'h1555, 1'b0, 39'h0, 6'd0, 1'b0},
        '{CMD_RGB,   13'h0AAA, 13'h1555, 13'h0AAA, 1'b0, 39'h0, 6'd0, 1'b0},
        '{CMD_RGB,   13'h1FFE, 13'h0001, 13'h1000, 1'b0, 39'h0, 6'd0, 1'b0},
        '{CMD_SYNC,  13'h0123, 13'h0456, 13'h0789, 1'b0, 39'h0, 6'd0, 1'b0},
        '{CMD_RGB,   13'h0FFF, 13'h1001, 13'h0800, 1'b0, 39'h0, 6'd0, 1'b0},
        '{CMD_HEAD,  13'h0F0F, 13'h10F0, 13'h0000, 1'b0, 39'h0, 6'd0, 1'b0},
        '{CMD_RESET, 13'h0000, 13'h1FFF, 13'h0AAA, 1'b0, 39'h0, 6'd0, 1'b0}
    };

    manchester_led_frame_serializer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("manchester_led_frame_serializer_unit test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Queue the cells of one bit group, MSB first
    function automatic void queue_bits(input logic [31:0] word, input int n,
                                       input bit preamble, input bit final_group);
        t_out due_cell;
        bit   is_last;
        for (int i = 0; i < n; i++) begin
            is_last              = final_group && (i == n - 1);
            due_cell.first_half  = word[31];
            due_cell.second_half = ~word[31];
            due_cell.end_low     = preamble && is_last;
            due_cell.last        = is_last;
            cells_due.push_back(due_cell);
            word = word << 1;
        end
    endfunction

    // Frame predictor: every cell that one command beat should produce
    function automatic void predict_cells(input t_in item);
        case (t_cmd'(item.cmd))
            CMD_SYNC:  queue_bits(SYNC_WORD,  SYNC_LEN, 1'b1, 1'b1);
            CMD_RESET: queue_bits(RESET_WORD, PRE_LEN,  1'b1, 1'b1);
            CMD_HEAD:  queue_bits(HEAD_WORD,  PRE_LEN,  1'b1, 1'b1);
            default: begin
                // pixel: three colour words, line left at its last level
                queue_bits(32'(item.red)   << (32 - LED_BITS), LED_BITS, 1'b0, 1'b0);
                queue_bits(32'(item.green) << (32 - LED_BITS), LED_BITS, 1'b0, 1'b0);
                queue_bits(32'(item.blue)  << (32 - LED_BITS), LED_BITS, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic logic [12:0] pick_colour();
        case ($urandom_range(7))
            0:       return 13'h0000;
            1:       return 13'h1FFF;
            default: return 13'($urandom);
        endcase
    endfunction

    task automatic check_cell(input t_out got);
        t_out want;
        cell_beats++;
        if (cells_due.size() == 0) begin
            report_mismatch($sformatf("cell beat %0d not expected (%b)", cell_beats, got));
            return;
        end
        want = cells_due.pop_front();
        if (got.first_half !== want.first_half)
            report_mismatch($sformatf("cell beat %0d first_half %b, want %b",
                                      cell_beats, got.first_half, want.first_half));
        if (got.second_half !== want.second_half)
            report_mismatch($sformatf("cell beat %0d second_half %b, want %b",
                                      cell_beats, got.second_half, want.second_half));
        if (got.end_low !== want.end_low)
            report_mismatch($sformatf("cell beat %0d end_low %b, want %b",
                                      cell_beats, got.end_low, want.end_low));
        if (got.last !== want.last)
            report_mismatch($sformatf("cell beat %0d last %b, want %b",
                                      cell_beats, got.last, want.last));
    endtask

    // Cell side: check what was taken at this edge, then set ready for the
    // next. A requested hold-off drops ready while hold_left counts down.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_cell(o_out_data);
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(99) >= 17);
        end
    end

    // Offer one command beat, with a random gap first; returns at the edge
    // that takes it, valid still high so a back-to-back beat can follow.
    task automatic send_cmd(input t_in item);
        while (!steady && $urandom_range(99) < 17) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        last_item_half = half_now;
    endtask

    // Wait for every cell, then let the last cell's line time run out
    task automatic settle();
        while (cells_due.size() != 0)
            @(posedge i_clk);
        repeat (4 * (last_item_half == 0 ? 1 : last_item_half) + 8)
            @(posedge i_clk);
    endtask

    task automatic write_half(input logic [15:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        half_now = 32'(value);
    endtask

    initial begin : main_seq
        t_in      item;
        t_dir_row row;
        t_out     due_cell;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at the reset half-bit length
        foreach (directed_rows[r]) begin
            row        = directed_rows[r];
            item.cmd   = row.cmd;
            item.red   = row.red;
            item.green = row.green;
            item.blue  = row.blue;
            send_cmd(item);
            if (row.typed) begin
                for (int k = int'(row.ncells) - 1; k >= 0; k--) begin
                    due_cell.first_half  = row.cells[k];
                    due_cell.second_half = ~row.cells[k];
                    due_cell.end_low     = row.ends_low && (k == 0);
                    due_cell.last        = (k == 0);
                    cells_due.push_back(due_cell);
                end
            end else begin
                predict_cells(item);
            end
        end
        i_in_valid <= 1'b0;

        // Longest half-bit: write only, no frame runs at this length.
        // The next phase rewrites it at once.
        settle();
        write_half(16'hFFFF);

        // Random phases; zero length (treated as one) and the shortest first
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            write_half(16'(phase_half[p]));
            steady = (p == 2);
            for (int n = 0; n < phase_items[p]; n++) begin
                if ((p == 0 && n == 35) || (p == 4 && n == 40))
                    hold_req = 1'b1;
                item.cmd   = ($urandom_range(99) < 55) ? CMD_RGB
                                                        : t_cmd'($urandom_range(2));
                item.red   = pick_colour();
                item.green = pick_colour();
                item.blue  = pick_colour();
                send_cmd(item);
                predict_cells(item);
            end
            i_in_valid <= 1'b0;
        end
        steady = 1'b0;

        settle();
        if (mismatch_count == 0)
            $display("manchester_led_frame_serializer_unit test passed");
        else
            $display("manchester_led_frame_serializer_unit test failed");
        $finish;
    end

endmodule
